FILE: hw/rtl/utp_pkg.sv
// UUID text parser package: format codes, character codes, base UUID
// constants, result struct and the hex digit decoder. No dependencies.
`timescale 1ns / 1ps

package utp_pkg;

  // Format of a parsed text
  typedef enum logic [1:0] {
    FMT_INVALID = 2'd0,
    FMT_16      = 2'd1,
    FMT_32      = 2'd2,
    FMT_128     = 2'd3
  } utp_fmt_t;

  // Characters with a role of their own
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_LOWER_X = 8'h78;  // 'x'
  localparam logic [7:0] CH_DASH    = 8'h2d;  // '-'

  // Position of the final character for each accepted length
  localparam logic [5:0] POS_END_16     = 6'd3;   // 4 digits
  localparam logic [5:0] POS_END_32     = 6'd7;   // 8 digits
  localparam logic [5:0] POS_END_16_PFX = 6'd5;   // "0x" + 4 digits
  localparam logic [5:0] POS_END_32_PFX = 6'd9;   // "0x" + 8 digits
  localparam logic [5:0] POS_END_128    = 6'd35;  // 36-character form
  localparam logic [5:0] LONG_LEN       = 6'd36;

  // Dash positions of the 36-character form
  localparam logic [5:0] DASH_POS_0 = 6'd8;
  localparam logic [5:0] DASH_POS_1 = 6'd13;
  localparam logic [5:0] DASH_POS_2 = 6'd18;
  localparam logic [5:0] DASH_POS_3 = 6'd23;

  // Base UUID 0000xxxx-0000-1000-8000-00805f9b34fb
  localparam logic [31:0] BASE_HIGH_TAIL = 32'h0000_1000;
  localparam logic [63:0] BASE_LOW       = 64'h8000_0080_5f9b_34fb;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } utp_hex_t;

  typedef struct packed {
    utp_fmt_t    fmt;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } utp_result_t;

  // Decode one ASCII hex digit of either case
  function automatic utp_hex_t hex_decode(input logic [7:0] c);
    utp_hex_t h;
    h.ok  = 1'b0;
    h.val = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      h.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = c[3:0] + 4'd9;
    end
    return h;
  endfunction

endpackage

FILE: hw/rtl/utp_if.sv
// Stream interfaces of the UUID text parser: character input and result output.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface utp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface utp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  format;
  logic [63:0] uuid_high;
  logic [63:0] uuid_low;

  modport source (output valid, format, uuid_high, uuid_low, input ready);
  modport sink   (input valid, format, uuid_high, uuid_low, output ready);
endinterface

FILE: hw/rtl/utp_accum.sv
// Per-character state of the UUID text parser: position, form flags, nibble
// shift register, and the result decision on the last character. Uses utp_pkg.
`timescale 1ns / 1ps

module utp_accum (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  output logic                 res_valid,
  output utp_pkg::utp_result_t res
);

  logic [5:0]   pos_r, pos_nxt;
  logic [3:0]   flags_r, flags_nxt;      // 0:c0 '0', 1:c1 'x', 2:c0 hex, 3:c1 hex
  logic         tail_ok_r, tail_ok_nxt;
  logic         long_ok_r, long_ok_nxt;
  logic [127:0] nib_r, nib_nxt;

  utp_pkg::utp_hex_t hex;
  logic              dash_pos;
  logic              short_ok;
  logic              pfx_ok;

  assign hex = utp_pkg::hex_decode(char_code);
  assign dash_pos = (pos_r == utp_pkg::DASH_POS_0) || (pos_r == utp_pkg::DASH_POS_1) ||
                    (pos_r == utp_pkg::DASH_POS_2) || (pos_r == utp_pkg::DASH_POS_3);

  // Update form flags with the current character
  always_comb begin
    flags_nxt   = flags_r;
    tail_ok_nxt = tail_ok_r;
    long_ok_nxt = long_ok_r;
    if (pos_r == 6'd0) begin
      flags_nxt[0] = flags_r[0] | (char_code == utp_pkg::CH_ZERO);
      flags_nxt[2] = flags_r[2] | hex.ok;
    end else if (pos_r == 6'd1) begin
      flags_nxt[1] = flags_r[1] | (char_code == utp_pkg::CH_LOWER_X);
      flags_nxt[3] = flags_r[3] | hex.ok;
    end else if (!hex.ok) begin
      tail_ok_nxt = 1'b0;
    end
    if (pos_r < utp_pkg::LONG_LEN) begin
      if (dash_pos) begin
        if (char_code != utp_pkg::CH_DASH) long_ok_nxt = 1'b0;
      end else if (!hex.ok) begin
        long_ok_nxt = 1'b0;
      end
    end
    nib_nxt = hex.ok ? {nib_r[123:0], hex.val} : nib_r;
    pos_nxt = (pos_r == '1) ? pos_r : pos_r + 6'd1;
  end

  // Decide the format from the updated flags
  assign short_ok = flags_nxt[2] && flags_nxt[3] && tail_ok_nxt;
  assign pfx_ok   = flags_nxt[0] && flags_nxt[1] && tail_ok_nxt;

  always_comb begin
    res.fmt = utp_pkg::FMT_INVALID;
    if ((pos_r == utp_pkg::POS_END_16 && short_ok) ||
        (pos_r == utp_pkg::POS_END_16_PFX && pfx_ok)) begin
      res.fmt = utp_pkg::FMT_16;
    end else if ((pos_r == utp_pkg::POS_END_32 && short_ok) ||
                 (pos_r == utp_pkg::POS_END_32_PFX && pfx_ok)) begin
      res.fmt = utp_pkg::FMT_32;
    end else if (pos_r == utp_pkg::POS_END_128 && long_ok_nxt) begin
      res.fmt = utp_pkg::FMT_128;
    end
    case (res.fmt)
      utp_pkg::FMT_16: begin
        res.uuid_high = {16'h0000, nib_nxt[15:0], utp_pkg::BASE_HIGH_TAIL};
        res.uuid_low  = utp_pkg::BASE_LOW;
      end
      utp_pkg::FMT_32: begin
        res.uuid_high = {nib_nxt[31:0], utp_pkg::BASE_HIGH_TAIL};
        res.uuid_low  = utp_pkg::BASE_LOW;
      end
      utp_pkg::FMT_128: begin
        res.uuid_high = nib_nxt[127:64];
        res.uuid_low  = nib_nxt[63:0];
      end
      default: begin
        res.uuid_high = 64'h0;
        res.uuid_low  = 64'h0;
      end
    endcase
  end

  assign res_valid = in_fire && last_char;

  // Advance control state per item; return to start after the last character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 6'd0;
      flags_r   <= 4'd0;
      tail_ok_r <= 1'b1;
      long_ok_r <= 1'b1;
    end else if (in_fire) begin
      if (last_char) begin
        pos_r     <= 6'd0;
        flags_r   <= 4'd0;
        tail_ok_r <= 1'b1;
        long_ok_r <= 1'b1;
      end else begin
        pos_r     <= pos_nxt;
        flags_r   <= flags_nxt;
        tail_ok_r <= tail_ok_nxt;
        long_ok_r <= long_ok_nxt;
      end
    end
  end

  // Shift in hex digits; older digits fall off the top
  always_ff @(posedge clk) begin
    if (in_fire) begin
      nib_r <= nib_nxt;
    end
  end

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last_char |=> pos_r == 6'd0 && flags_r == 4'd0)
    else $error("position not restarted after last character");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !last_char && pos_r != 6'h3f |=> pos_r == $past(pos_r) + 6'd1)
    else $error("position did not advance by one");

endmodule

FILE: hw/rtl/utp_out_reg.sv
// Result register of the UUID text parser: holds one result until taken.
// Uses utp_pkg for the result struct.
`timescale 1ns / 1ps

module utp_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  utp_pkg::utp_result_t res,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 can_load,
  output utp_pkg::utp_result_t res_out
);

  logic                 valid_r;
  utp_pkg::utp_result_t res_r;

  // Free when empty or when the held item leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Capture payload on load
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && valid_r && !out_ready))
    else $error("held result overwritten");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.fmt == utp_pkg::FMT_INVALID |-> res_r.uuid_high == 64'h0 &&
      res_r.uuid_low == 64'h0)
    else $error("invalid format with nonzero value");

endmodule

FILE: hw/rtl/uuid_text_parser.sv
// UUID text parser, top level: character input channel, result output channel.
// Instantiates utp_accum and utp_out_reg; uses utp_pkg and utp_if.
//
// Takes a UUID text one character per item, with last_char set on the final
// character, and gives one result (format code and the 128-bit expanded UUID)
// for that final character; other characters give no result. Accepted forms
// are 4 or 8 hex digits, the same with a lower-case "0x" prefix, and the
// 36-character dashed form; short forms are expanded with the Bluetooth base
// UUID, anything else gives format 0 and a zero value. One character is taken
// every cycle unless the input is stalled; the result appears in the output
// register in the cycle after its last character. The input stalls only while
// a finished result sits in the output register and the sink is not ready.
`timescale 1ns / 1ps

module uuid_text_parser (
  input  logic      clk,
  input  logic      rst_n,
  utp_in_if.sink    in_ch,
  utp_out_if.source out_ch
);

  logic                 in_fire;
  logic                 res_valid;
  logic                 can_load;
  logic                 out_valid;
  utp_pkg::utp_result_t res;
  utp_pkg::utp_result_t res_out;

  assign in_ch.ready = can_load;
  assign in_fire     = in_ch.valid && can_load;

  utp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .char_code (in_ch.char_code),
    .last_char (in_ch.last_char),
    .res_valid (res_valid),
    .res       (res)
  );

  utp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_out   (res_out)
  );

  // Drive the result channel
  assign out_ch.valid     = out_valid;
  assign out_ch.format    = res_out.fmt;
  assign out_ch.uuid_high = res_out.uuid_high;
  assign out_ch.uuid_low  = res_out.uuid_low;

endmodule

FILE: bench/tb_top.sv
// Testbench for uuid_text_parser: streams UUID texts one character per item and
// compares every result against an in-bench parser model. Uses utp_pkg, utp_if.
`timescale 1ns / 1ps

module tb_top;

  // Characters the parser treats specially
  localparam logic [7:0] C_ZERO    = "0";
  localparam logic [7:0] C_LOWER_X = "x";
  localparam logic [7:0] C_UPPER_X = "X";
  localparam logic [7:0] C_DASH    = "-";
  localparam logic [7:0] C_LOWER_A = "a";
  localparam logic [7:0] C_UPPER_A = "A";

  // Base UUID pieces used to expand short forms
  localparam logic [31:0] BASE_HI_LSW  = 32'h0000_1000;
  localparam logic [63:0] BASE_LO_WORD = 64'h8000_0080_5f9b_34fb;

  // Text lengths and layout of the dashed form
  localparam int LEN_SHORT_16  = 4;
  localparam int LEN_SHORT_32  = 8;
  localparam int LEN_PREFIX_16 = 6;
  localparam int LEN_PREFIX_32 = 10;
  localparam int LEN_LONG      = 36;
  localparam int POS_SATURATED = 63;

  localparam int TARGET_CHARS = 750;
  localparam int HOLD_AFTER   = 12;    // results seen before the long sink hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n;

  utp_in_if  in_ch ();
  utp_out_if out_ch ();

  uuid_text_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_char_t           pending_chars[$];
  utp_pkg::utp_result_t expected_uuids[$];
  logic [7:0]           text_buf[$];

  int chars_queued   = 0;
  int texts_queued   = 0;
  int chars_accepted = 0;
  int results_seen   = 0;
  int full_seen      = 0;
  int short_seen     = 0;
  int invalid_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int gap_left;
  int stall_left;
  int hold_count;
  logic hold_on;
  logic hold_done;

  // Parser model state
  logic [5:0]  m_pos;
  logic [3:0]  m_flags;   // 0: first is '0', 1: second is 'x', 2/3: first/second hex
  logic        m_tail_ok;
  logic        m_long_ok;
  logic [63:0] m_hi;
  logic [63:0] m_lo;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hex digit of either case; returns 1 and its value, or 0
  function automatic logic char_nibble(input logic [7:0] c, output logic [3:0] v);
    logic ok;
    ok = 1'b1;
    v  = 4'd0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
    else ok = 1'b0;
    return ok;
  endfunction

  function automatic void clear_parser_model();
    m_pos     = '0;
    m_flags   = '0;
    m_tail_ok = 1'b1;
    m_long_ok = 1'b1;
    m_hi      = '0;
    m_lo      = '0;
  endfunction

  // Advance the model by one character; queue a result on the final one
  function automatic void predict_char(input logic [7:0] c, input logic last);
    logic [3:0]           nib;
    logic                 hex;
    int                   len;
    utp_pkg::utp_result_t r;
    hex = char_nibble(c, nib);
    if (m_pos == 6'd0) begin
      if (c == C_ZERO) m_flags[0] = 1'b1;
      if (hex) m_flags[2] = 1'b1;
    end else if (m_pos == 6'd1) begin
      if (c == C_LOWER_X) m_flags[1] = 1'b1;
      if (hex) m_flags[3] = 1'b1;
    end else if (!hex) begin
      m_tail_ok = 1'b0;
    end
    if (m_pos < LEN_LONG) begin
      if (m_pos == 6'd8 || m_pos == 6'd13 || m_pos == 6'd18 || m_pos == 6'd23) begin
        if (c != C_DASH) m_long_ok = 1'b0;
      end else if (!hex) begin
        m_long_ok = 1'b0;
      end
    end
    if (hex) {m_hi, m_lo} = {m_hi[59:0], m_lo, nib};
    if (!last) begin
      if (m_pos != POS_SATURATED) m_pos = m_pos + 6'd1;
    end else begin
      len         = int'(m_pos) + 1;
      r.fmt       = utp_pkg::FMT_INVALID;
      r.uuid_high = '0;
      r.uuid_low  = '0;
      if ((len == LEN_SHORT_16 || len == LEN_SHORT_32) && m_flags[2] && m_flags[3]
          && m_tail_ok) begin
        r.fmt = (len == LEN_SHORT_16) ? utp_pkg::FMT_16 : utp_pkg::FMT_32;
      end else if ((len == LEN_PREFIX_16 || len == LEN_PREFIX_32) && m_flags[0]
                   && m_flags[1] && m_tail_ok) begin
        r.fmt = (len == LEN_PREFIX_16) ? utp_pkg::FMT_16 : utp_pkg::FMT_32;
      end else if (len == LEN_LONG && m_long_ok) begin
        r.fmt = utp_pkg::FMT_128;
      end
      case (r.fmt)
        utp_pkg::FMT_16: begin
          r.uuid_high = {16'h0000, m_lo[15:0], BASE_HI_LSW};
          r.uuid_low  = BASE_LO_WORD;
        end
        utp_pkg::FMT_32: begin
          r.uuid_high = {m_lo[31:0], BASE_HI_LSW};
          r.uuid_low  = BASE_LO_WORD;
        end
        utp_pkg::FMT_128: begin
          r.uuid_high = m_hi;
          r.uuid_low  = m_lo;
        end
        default: ;
      endcase
      expected_uuids.push_back(r);
      clear_parser_model();
    end
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    utp_pkg::utp_result_t want;
    if (expected_uuids.size() == 0) begin
      report_error($sformatf("result with nothing expected, format %0d", out_ch.format));
    end else begin
      want = expected_uuids.pop_front();
      case (want.fmt)
        utp_pkg::FMT_128:                  full_seen++;
        utp_pkg::FMT_16, utp_pkg::FMT_32:  short_seen++;
        default:                           invalid_seen++;
      endcase
      if (out_ch.format !== want.fmt)
        report_error($sformatf("format got %0d want %0d", out_ch.format, want.fmt));
      if (out_ch.uuid_high !== want.uuid_high)
        report_error($sformatf("uuid_high got %h want %h", out_ch.uuid_high,
                               want.uuid_high));
      if (out_ch.uuid_low !== want.uuid_low)
        report_error($sformatf("uuid_low got %h want %h", out_ch.uuid_low, want.uuid_low));
    end
  endtask

  // Stimulus helpers: build a text in text_buf, then queue it as items
  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return C_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? C_LOWER_A : C_UPPER_A) + 8'(v - 10);
  endfunction

  function automatic void make_short(input int digits, input bit prefixed);
    text_buf.delete();
    if (prefixed) begin
      text_buf.push_back(C_ZERO);
      text_buf.push_back(C_LOWER_X);
    end
    repeat (digits) text_buf.push_back(rand_hex_char());
  endfunction

  function automatic void make_long();
    text_buf.delete();
    for (int i = 0; i < LEN_LONG; i++) begin
      if (i == 8 || i == 13 || i == 18 || i == 23) text_buf.push_back(C_DASH);
      else text_buf.push_back(rand_hex_char());
    end
  endfunction

  function automatic void make_valid_text();
    case ($urandom_range(0, 2))
      0:       make_short($urandom_range(0, 1) ? LEN_SHORT_16 : LEN_SHORT_32, 1'b0);
      1:       make_short($urandom_range(0, 1) ? LEN_SHORT_16 : LEN_SHORT_32, 1'b1);
      default: make_long();
    endcase
  endfunction

  function automatic void send_text();
    text_char_t tc;
    for (int i = 0; i < text_buf.size(); i++) begin
      tc.code = text_buf[i];
      tc.last = (i == text_buf.size() - 1);
      pending_chars.push_back(tc);
    end
    chars_queued += text_buf.size();
    texts_queued++;
  endfunction

  function automatic void send_literal(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endfunction

  // Fill the item queue and apply reset
  initial begin
    int kind;
    int n;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    out_ch.ready    = 1'b0;
    clear_parser_model();

    // Directed: hex extremes, both prefix mistakes, lone non-hex bytes
    send_literal("FfA9");
    send_literal("0x09aF");
    send_literal("0X12");
    send_literal("0x12");
    send_literal("0x123456");
    text_buf.delete();
    text_buf.push_back(8'hff);
    send_text();
    text_buf.delete();
    text_buf.push_back(8'h00);
    send_text();

    // Random: mostly well-formed texts, some corrupted, some noise
    while (chars_queued < TARGET_CHARS) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        make_short($urandom_range(0, 1) ? LEN_SHORT_16 : LEN_SHORT_32, 1'b0);
      end else if (kind < 45) begin
        make_short($urandom_range(0, 1) ? LEN_SHORT_16 : LEN_SHORT_32, 1'b1);
      end else if (kind < 65) begin
        make_long();
      end else if (kind < 75) begin
        text_buf.delete();
        n = $urandom_range(1, 12);
        repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 79) begin
        // overlong text, some of it past the saturation point of the position counter
        make_long();
        n = $urandom_range(60, 72);
        while (text_buf.size() < n) text_buf.push_back(rand_hex_char());
      end else begin
        make_valid_text();
        n = $urandom_range(0, text_buf.size() - 1);
        case ($urandom_range(0, 4))
          0: text_buf[n] = 8'($urandom_range(0, 255));
          1: if (text_buf.size() > 1) void'(text_buf.pop_back());
          2: text_buf.push_back(rand_hex_char());
          3: if (text_buf.size() > 1) text_buf[1] = C_UPPER_X;
          default: text_buf[n] = C_DASH;
        endcase
      end
      send_text();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stream to drain, then let stray results show up
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_ch.valid || expected_uuids.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d characters in %0d texts, %0d results checked", chars_accepted,
             texts_queued, results_seen);
    $display("results: %0d dashed, %0d short, %0d invalid; %0d mismatches", full_seen,
             short_seen, invalid_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Character driver: predict on acceptance, then idle a random gap
  always @(posedge clk) begin : char_driver
    int         gap_now;
    text_char_t next_char;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_code <= '0;
      in_ch.last_char <= 1'b0;
      gap_left        <= 0;
    end else begin
      gap_now = gap_left;
      if (in_ch.valid && in_ch.ready) begin
        predict_char(in_ch.char_code, in_ch.last_char);
        chars_accepted++;
        gap_now = (chars_accepted % 192 >= 128) ? 0 : $urandom_range(0, 8);
      end
      // Hold a stalled item; otherwise idle or offer the next one
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_now > 0) begin
          in_ch.valid <= 1'b0;
          gap_now--;
        end else if (pending_chars.size() != 0) begin
          next_char        = pending_chars.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.char_code <= next_char.code;
          in_ch.last_char <= next_char.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      gap_left <= gap_now;
    end
  end

  // Result monitor and sink: check each item, then stall a random count
  always @(posedge clk) begin : result_monitor
    int stall_now;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin
      stall_now = stall_left;
      if (out_ch.valid && out_ch.ready) begin
        check_result();
        results_seen <= results_seen + 1;
        stall_now = ((results_seen / 16) % 3 == 2) ? 0 : $urandom_range(0, 8);
      end
      if (hold_on) begin
        out_ch.ready <= 1'b0;
      end else if (stall_now > 0) begin
        out_ch.ready <= 1'b0;
        stall_now--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      stall_left <= stall_now;
    end
  end

  // Long sink hold-off, once, so the parser backs up and stalls its input
  always @(posedge clk) begin : sink_hold
    if (!rst_n) begin
      hold_on    <= 1'b0;
      hold_done  <= 1'b0;
      hold_count <= 0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_on    <= (hold_count != HOLD_CYCLES - 1);
      hold_done  <= (hold_count == HOLD_CYCLES - 1);
      hold_count <= hold_count + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

endmodule
